// ===== rtl/mcdt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the multi-channel countdown timer unit.
// No dependencies; every other file in rtl/ imports this package.
package mcdt_pkg;

	localparam int MaxTimers      = 8;
	localparam int NumTimersDef   = 8;
	localparam int CountWidthDef  = 32;
	localparam int DataWidth      = 32;
	localparam int AddrWidth      = 8;
	localparam int FuncWidth      = 2;
	localparam int TimerIdxWidth  = 3;
	localparam int OfsWidth       = 5;
	localparam int WinBytes       = 20;
	// floor(a / 20) == (a * 205) >> 12 for every a below the global base
	localparam int WinRecip       = 205;
	localparam int WinRecipShift  = 12;

	localparam logic [FuncWidth-1:0] FUNC_READ  = 2'd0;
	localparam logic [FuncWidth-1:0] FUNC_WRITE = 2'd1;
	localparam logic [FuncWidth-1:0] FUNC_TICK  = 2'd2;

	localparam logic [AddrWidth-1:0] ADDR_GLOBAL = 8'hA0;
	localparam logic [AddrWidth-1:0] ADDR_TIS    = 8'hA0;
	localparam logic [AddrWidth-1:0] ADDR_TEOI   = 8'hA4;
	localparam logic [AddrWidth-1:0] ADDR_TRIS   = 8'hA8;
	localparam logic [AddrWidth-1:0] ADDR_TCV    = 8'hAC;

	localparam logic [OfsWidth-1:0] OFS_LOAD = 5'd0;
	localparam logic [OfsWidth-1:0] OFS_CUR  = 5'd4;
	localparam logic [OfsWidth-1:0] OFS_CTL  = 5'd8;
	localparam logic [OfsWidth-1:0] OFS_EOI  = 5'd12;
	localparam logic [OfsWidth-1:0] OFS_STS  = 5'd16;

	localparam int CTL_ENABLE_BIT = 0;
	localparam int CTL_RELOAD_BIT = 1;
	localparam int CTL_MASK_BIT   = 2;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_LOAD,
		KIND_CUR,
		KIND_CTL,
		KIND_EOI,
		KIND_STS
	} reg_kind_t;

	typedef enum logic [1:0] {
		GLB_NONE,
		GLB_TIS,
		GLB_TEOI,
		GLB_TRIS
	} glob_kind_t;

	// decoded operation, valid only in the cycle the item is processed
	typedef struct packed {
		logic                 rd;
		logic                 wr;
		logic                 tick;
		logic                 clr_all;
		reg_kind_t            kind;
		glob_kind_t           glob;
		logic [MaxTimers-1:0] sel;
	} mcdt_op_t;

	typedef struct packed {
		logic raw_q;
		logic masked_q;
		logic masked_d;
	} mcdt_sts_t;

endpackage

// ===== rtl/mcdt_decode.sv =====
`timescale 1ns / 1ps
// Address and function decode: splits a byte offset into timer window and word.
// Depends on mcdt_pkg.
module mcdt_decode #(
	parameter int NUM_TIMERS = mcdt_pkg::NumTimersDef
) (
	input  logic                           valid,
	input  logic [mcdt_pkg::FuncWidth-1:0] func,
	input  logic [mcdt_pkg::AddrWidth-1:0] address,
	output mcdt_pkg::mcdt_op_t             op
);
	import mcdt_pkg::*;

	logic [15:0]              prod;
	logic [TimerIdxWidth-1:0] tidx;
	logic [AddrWidth-1:0]     ofs_full;
	logic [OfsWidth-1:0]      ofs;
	logic                     in_win;

	always_comb begin
		prod     = 16'(address) * 16'(WinRecip);
		tidx     = prod[WinRecipShift +: TimerIdxWidth];
		ofs_full = address - 8'(8'(tidx) * 8'(WinBytes));
		ofs      = ofs_full[OfsWidth-1:0];
		in_win   = address < ADDR_GLOBAL;
	end

	always_comb begin
		op         = '0;
		op.kind    = KIND_NONE;
		op.glob    = GLB_NONE;
		op.rd      = valid && (func == FUNC_READ);
		op.wr      = valid && (func == FUNC_WRITE);
		op.tick    = valid && (func == FUNC_TICK);
		for (int i = 0; i < MaxTimers; i++) begin
			op.sel[i] = in_win && (i < NUM_TIMERS) && (tidx == TimerIdxWidth'(i));
		end
		if (in_win) begin
			case (ofs)
				OFS_LOAD: op.kind = KIND_LOAD;
				OFS_CUR:  op.kind = KIND_CUR;
				OFS_CTL:  op.kind = KIND_CTL;
				OFS_EOI:  op.kind = KIND_EOI;
				OFS_STS:  op.kind = KIND_STS;
				default:  op.kind = KIND_NONE;
			endcase
		end else begin
			case (address)
				ADDR_TIS:  op.glob = GLB_TIS;
				ADDR_TEOI: op.glob = GLB_TEOI;
				ADDR_TRIS: op.glob = GLB_TRIS;
				ADDR_TCV:  op.glob = GLB_NONE;
				default:   op.glob = GLB_NONE;
			endcase
		end
		op.clr_all = op.rd && (op.glob == GLB_TEOI);
	end

endmodule

// ===== rtl/mcdt_channel.sv =====
`timescale 1ns / 1ps
// One countdown timer: load, count, control and status bits, with its read mux.
// Depends on mcdt_pkg.
module mcdt_channel #(
	parameter int IDX         = 0,
	parameter int COUNT_WIDTH = mcdt_pkg::CountWidthDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mcdt_pkg::mcdt_op_t             op,
	input  logic [mcdt_pkg::DataWidth-1:0] wr_data,
	output logic [mcdt_pkg::DataWidth-1:0] rd_data,
	output mcdt_pkg::mcdt_sts_t            sts
);
	import mcdt_pkg::*;

	logic [COUNT_WIDTH-1:0] load_q, load_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic [DataWidth-1:0]   ctl_q, ctl_d;
	logic                   raw_q, raw_d;
	logic                   masked_q, masked_d;
	logic                   sel, en, expire;

	always_comb begin
		sel    = op.sel[IDX];
		en     = ctl_q[CTL_ENABLE_BIT];
		expire = (count_q[COUNT_WIDTH-1:1] == '0);

		load_d   = load_q;
		count_d  = count_q;
		ctl_d    = ctl_q;
		raw_d    = raw_q;
		masked_d = masked_q;

		if (op.tick && en) begin
			if (expire) begin
				raw_d = 1'b1;
				if (!ctl_q[CTL_MASK_BIT])
					masked_d = 1'b1;
				count_d = ctl_q[CTL_RELOAD_BIT] ? load_q : '1;
			end else begin
				count_d = count_q - COUNT_WIDTH'(1);
			end
		end

		if (op.wr && sel) begin
			case (op.kind)
				KIND_LOAD: load_d = wr_data[COUNT_WIDTH-1:0];
				KIND_CTL: begin
					if (wr_data[CTL_ENABLE_BIT]) begin
						ctl_d   = wr_data;
						count_d = load_q;
					end else begin
						// disable: wipe the whole timer
						ctl_d    = '0;
						load_d   = '0;
						count_d  = '0;
						raw_d    = 1'b0;
						masked_d = 1'b0;
					end
				end
				default: ;
			endcase
		end

		if ((op.rd && sel && en && op.kind == KIND_EOI) || op.clr_all) begin
			raw_d    = 1'b0;
			masked_d = 1'b0;
		end
	end

	always_comb begin
		rd_data = '0;
		if (op.rd && sel && en) begin
			case (op.kind)
				KIND_LOAD: rd_data = DataWidth'(load_q);
				KIND_CUR:  rd_data = DataWidth'(count_q);
				KIND_CTL:  rd_data = ctl_q;
				KIND_STS:  rd_data = DataWidth'(masked_q);
				default:   rd_data = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q   <= '0;
			count_q  <= '0;
			ctl_q    <= '0;
			raw_q    <= 1'b0;
			masked_q <= 1'b0;
		end else begin
			load_q   <= load_d;
			count_q  <= count_d;
			ctl_q    <= ctl_d;
			raw_q    <= raw_d;
			masked_q <= masked_d;
		end
	end

	assign sts.raw_q    = raw_q;
	assign sts.masked_q = masked_q;
	assign sts.masked_d = masked_d;

endmodule

// ===== rtl/multi_channel_countdown_timer_unit.sv =====
`timescale 1ns / 1ps
// Each item passes the input register, then the result register, to its result.
// Throughput: one item per cycle unless stalled; enabled timers step together on a tick.
// The input register stalls only while the result register holds an untaken item.
// Reset (arst_n low, asynchronous) stops all timers and clears every timer register
// and status bit; both pipeline stages come out empty.
module multi_channel_countdown_timer_unit #(
	parameter int NUM_TIMERS  = mcdt_pkg::NumTimersDef,
	parameter int COUNT_WIDTH = mcdt_pkg::CountWidthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] address, [39:8] write_data
	input  logic [1:0]  s_tuser,   // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [31:0] read_data, [39:32] irq_lines
);
	import mcdt_pkg::*;

	localparam logic [MaxTimers-1:0] TimerMask = MaxTimers'((1 << NUM_TIMERS) - 1);

	logic                 valid_s1;
	logic [FuncWidth-1:0] func_s1;
	logic [AddrWidth-1:0] addr_s1;
	logic [DataWidth-1:0] wdata_s1;

	logic                 out_valid_q;
	logic [DataWidth-1:0] read_data_q;
	logic [MaxTimers-1:0] irq_q;

	logic                 advance;
	mcdt_op_t             op;
	logic [DataWidth-1:0] chan_rd [NUM_TIMERS];
	mcdt_sts_t            chan_sts [NUM_TIMERS];
	logic [DataWidth-1:0] rd_or, rd_final;
	logic [MaxTimers-1:0] raw_vec, masked_vec, masked_nxt;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1  <= s_tuser;
			addr_s1  <= s_tdata[7:0];
			wdata_s1 <= s_tdata[39:8];
		end
	end

	mcdt_decode #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_decode (
		.valid   (advance),
		.func    (func_s1),
		.address (addr_s1),
		.op      (op)
	);

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_chan
		mcdt_channel #(
			.IDX         (i),
			.COUNT_WIDTH (COUNT_WIDTH)
		) u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (op),
			.wr_data (wdata_s1),
			.rd_data (chan_rd[i]),
			.sts     (chan_sts[i])
		);
	end

	always_comb begin
		rd_or      = '0;
		raw_vec    = '0;
		masked_vec = '0;
		masked_nxt = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			rd_or         = rd_or | chan_rd[i];
			raw_vec[i]    = chan_sts[i].raw_q;
			masked_vec[i] = chan_sts[i].masked_q;
			masked_nxt[i] = chan_sts[i].masked_d;
		end
		rd_final = rd_or;
		if (op.rd) begin
			case (op.glob)
				GLB_TIS:  rd_final = DataWidth'(masked_vec);
				GLB_TRIS: rd_final = DataWidth'(raw_vec);
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rd_final;
			irq_q       <= masked_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {irq_q, read_data_q};

	// hold the input stage while the result waits
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |=> valid_s1)
		else $error("input stage dropped an item under back-pressure");

	a_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && func_s1 == FUNC_TICK |=> read_data_q == '0)
		else $error("tick item returned nonzero read data");

	a_irq_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (irq_q & ~TimerMask) == '0)
		else $error("interrupt line set for a missing timer");

	a_masked_raw: assert property (@(posedge clk) disable iff (!arst_n)
		(masked_vec & ~raw_vec) == '0)
		else $error("masked status set without raw status");

endmodule
